@@ rtl/core/pdbc_pkg.sv @@
// shared types, constants and register map of the pwm duty band classifier
`timescale 1ns / 1ps
`default_nettype none
package pdbc_pkg;

	// tick counter width default
	localparam int CNT_W_DEFAULT = 20;

	// duty bounds are tenths of a percent
	localparam int BOUND_W = 10;
	localparam int DUTY_SCALE = 1000;
	localparam int CHAN_W = 8;
	localparam int BAND_W = 2;

	// result queue between the front and back parts
	localparam int QUEUE_DEPTH = 4;

	// apb port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// register indexes, byte address is four times the index
	localparam logic [2:0] REG_CHANNEL_ID = 3'd0;
	localparam logic [2:0] REG_HIGH_LOWER = 3'd1;
	localparam logic [2:0] REG_MID_LOWER = 3'd2;
	localparam logic [2:0] REG_LOW_LOWER = 3'd3;
	localparam logic [2:0] REG_LOW_UPPER = 3'd4;

	// register reset values
	localparam logic [CHAN_W-1:0] RST_CHANNEL_ID = 8'd0;
	localparam logic [BOUND_W-1:0] RST_HIGH_LOWER = 10'd55;
	localparam logic [BOUND_W-1:0] RST_MID_LOWER = 10'd85;
	localparam logic [BOUND_W-1:0] RST_LOW_LOWER = 10'd115;
	localparam logic [BOUND_W-1:0] RST_LOW_UPPER = 10'd145;

	// band codes
	typedef enum logic [BAND_W-1:0] {
		BAND_HIGH = 2'd0,
		BAND_MID = 2'd1,
		BAND_LOW = 2'd2,
		BAND_ERROR = 2'd3
	} band_t;

	// configuration seen by the back part
	typedef struct packed {
		logic [CHAN_W-1:0] channel_id;
		logic [BOUND_W-1:0] high_lower;
		logic [BOUND_W-1:0] mid_lower;
		logic [BOUND_W-1:0] low_lower;
		logic [BOUND_W-1:0] low_upper;
	} cfg_t;

	// front part phase
	typedef enum logic [2:0] {
		PH_WAIT = 3'b001,
		PH_HIGH = 3'b010,
		PH_LOW = 3'b100
	} phase_t;

endpackage
`default_nettype wire

@@ rtl/core/pdbc_ifs.sv @@
// valid/ready channel interfaces for pin samples and band results
`timescale 1ns / 1ps
`default_nettype none
interface pdbc_sample_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

interface pdbc_result_if;
	logic valid;
	logic ready;
	logic [7:0] channel_index;
	logic [1:0] band_code;

	modport source (output valid, output channel_index, output band_code, input ready);
	modport sink (input valid, input channel_index, input band_code, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pdbc_regs.sv @@
// apb configuration registers
`timescale 1ns / 1ps
`default_nettype none
module pdbc_regs import pdbc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign idx = paddr[4:2];
	assign cfg = cfg_q;

	// register writes, indexes past the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_id <= RST_CHANNEL_ID;
			cfg_q.high_lower <= RST_HIGH_LOWER;
			cfg_q.mid_lower <= RST_MID_LOWER;
			cfg_q.low_lower <= RST_LOW_LOWER;
			cfg_q.low_upper <= RST_LOW_UPPER;
		end else if (wr_en) begin
			unique case (idx)
				REG_CHANNEL_ID: cfg_q.channel_id <= pwdata[CHAN_W-1:0];
				REG_HIGH_LOWER: cfg_q.high_lower <= pwdata[BOUND_W-1:0];
				REG_MID_LOWER: cfg_q.mid_lower <= pwdata[BOUND_W-1:0];
				REG_LOW_LOWER: cfg_q.low_lower <= pwdata[BOUND_W-1:0];
				REG_LOW_UPPER: cfg_q.low_upper <= pwdata[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_CHANNEL_ID: prdata = DATA_W'(cfg_q.channel_id);
			REG_HIGH_LOWER: prdata = DATA_W'(cfg_q.high_lower);
			REG_MID_LOWER: prdata = DATA_W'(cfg_q.mid_lower);
			REG_LOW_LOWER: prdata = DATA_W'(cfg_q.low_lower);
			REG_LOW_UPPER: prdata = DATA_W'(cfg_q.low_upper);
			default: prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/pdbc_front.sv @@
// front part: edge tracking and saturating high/period tick counters
`timescale 1ns / 1ps
`default_nettype none
module pdbc_front import pdbc_pkg::*; #(
	parameter int COUNT_WIDTH = CNT_W_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	pdbc_sample_if.sink samples,
	input wire logic q_full,
	output logic q_push,
	output logic [2*COUNT_WIDTH-1:0] q_wdata
);

	phase_t phase_q;
	logic [COUNT_WIDTH-1:0] period_q;
	logic [COUNT_WIDTH-1:0] high_q;
	logic [COUNT_WIDTH-1:0] period_inc;
	logic [COUNT_WIDTH-1:0] high_inc;
	logic accept;
	logic pin;

	assign samples.ready = ~q_full;
	assign accept = samples.valid & ~q_full;
	assign pin = samples.pin_level;

	// saturating increments
	assign period_inc = (&period_q) ? period_q : period_q + COUNT_WIDTH'(1);
	assign high_inc = (&high_q) ? high_q : high_q + COUNT_WIDTH'(1);

	// a rising edge in the low part closes a period
	assign q_push = accept & pin & (phase_q == PH_LOW);
	assign q_wdata = {high_q, period_q};

	// phase and counters change only on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			period_q <= '0;
			high_q <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HIGH: begin
					period_q <= period_inc;
					if (pin) begin
						high_q <= high_inc;
					end else begin
						phase_q <= PH_LOW;
					end
				end
				PH_LOW: begin
					if (pin) begin
						period_q <= COUNT_WIDTH'(1);
						high_q <= COUNT_WIDTH'(1);
						phase_q <= PH_HIGH;
					end else begin
						period_q <= period_inc;
					end
				end
				default: begin
					if (pin) begin
						period_q <= COUNT_WIDTH'(1);
						high_q <= COUNT_WIDTH'(1);
						phase_q <= PH_HIGH;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/pdbc_queue.sv @@
// small register fifo between the front and back parts
`timescale 1ns / 1ps
`default_nettype none
module pdbc_queue import pdbc_pkg::*; #(
	parameter int WIDTH = 2 * CNT_W_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic full,
	output logic not_empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign full = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign do_push = push & ~full;
	assign do_pop = pop & not_empty;
	assign rdata = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push & ~do_pop) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_pop & ~do_push) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/pdbc_back.sv @@
// back part: cross-multiplied duty compare and band output register
`timescale 1ns / 1ps
`default_nettype none
module pdbc_back import pdbc_pkg::*; #(
	parameter int COUNT_WIDTH = CNT_W_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_not_empty,
	input wire logic [2*COUNT_WIDTH-1:0] q_rdata,
	output logic q_pop,
	input wire cfg_t cfg,
	pdbc_result_if.source results
);

	localparam int PW = COUNT_WIDTH + BOUND_W;

	logic [COUNT_WIDTH-1:0] high_ticks;
	logic [COUNT_WIDTH-1:0] period_ticks;
	logic valid_s1;
	logic [PW-1:0] scaled_s1;
	logic [PW-1:0] hl_s1;
	logic [PW-1:0] ml_s1;
	logic [PW-1:0] ll_s1;
	logic [PW-1:0] lu_s1;
	logic out_valid_q;
	logic [CHAN_W-1:0] out_chan_q;
	band_t out_band_q;
	logic out_en;
	logic s1_en;
	logic in_high;
	logic in_mid;
	logic in_low;
	band_t band;

	assign high_ticks = q_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
	assign period_ticks = q_rdata[COUNT_WIDTH-1:0];

	// stall chain from the output register back to the queue
	assign out_en = ~out_valid_q | results.ready;
	assign s1_en = ~valid_s1 | out_en;
	assign q_pop = q_not_empty & s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				valid_s1 <= q_not_empty;
			end
			if (out_en) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// stage 1: scaled high time and bound times period
	always_ff @(posedge clk) begin
		if (s1_en) begin
			scaled_s1 <= PW'(high_ticks) * PW'(DUTY_SCALE);
			hl_s1 <= PW'(cfg.high_lower) * PW'(period_ticks);
			ml_s1 <= PW'(cfg.mid_lower) * PW'(period_ticks);
			ll_s1 <= PW'(cfg.low_lower) * PW'(period_ticks);
			lu_s1 <= PW'(cfg.low_upper) * PW'(period_ticks);
		end
	end

	// stage 2: strict window tests, first window that holds wins
	assign in_high = (scaled_s1 > hl_s1) & (scaled_s1 < ml_s1);
	assign in_mid = (scaled_s1 > ml_s1) & (scaled_s1 < ll_s1);
	assign in_low = (scaled_s1 > ll_s1) & (scaled_s1 < lu_s1);

	always_comb begin
		if (in_high) begin
			band = BAND_HIGH;
		end else if (in_mid) begin
			band = BAND_MID;
		end else if (in_low) begin
			band = BAND_LOW;
		end else begin
			band = BAND_ERROR;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_en) begin
			out_chan_q <= cfg.channel_id;
			out_band_q <= band;
		end
	end

	assign results.valid = out_valid_q;
	assign results.channel_index = out_chan_q;
	assign results.band_code = out_band_q;

endmodule
`default_nettype wire

@@ rtl/core/pwm_duty_band_classifier_core.sv @@
// top level of the pwm duty band classifier
//
//  port      | direction | handshake        | carries
//  ----------+-----------+------------------+------------------------------
//  samples   | in        | valid / ready    | pin_level, one pin sample per word
//  results   | out       | valid / ready    | channel_index, band_code
//  apb       | in        | psel / penable   | five config registers at 4*index
//
// one sample word is taken every clock while the result queue has room.
// after the closing sample is taken, its band word passes the queue register,
// the multiply stage and the output register in that order.
// samples stall only when four results wait in the queue behind a stalled output.
// reset clears the phase, the tick counters and the queue; registers take defaults.
`timescale 1ns / 1ps
`default_nettype none
module pwm_duty_band_classifier_core import pdbc_pkg::*; #(
	parameter int COUNT_WIDTH = CNT_W_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	pdbc_sample_if.sink samples,
	pdbc_result_if.source results,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	cfg_t cfg;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_not_empty;
	logic [2*COUNT_WIDTH-1:0] q_wdata;
	logic [2*COUNT_WIDTH-1:0] q_rdata;

	// configuration registers
	pdbc_regs u_regs (
		.clk (clk),
		.arst_n (arst_n),
		.psel (psel),
		.penable (penable),
		.pwrite (pwrite),
		.paddr (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg (cfg)
	);

	// edge tracking and counting
	pdbc_front #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk (clk),
		.arst_n (arst_n),
		.samples (samples),
		.q_full (q_full),
		.q_push (q_push),
		.q_wdata (q_wdata)
	);

	// decoupling queue of closed periods
	pdbc_queue #(
		.WIDTH (2 * COUNT_WIDTH)
	) u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.push (q_push),
		.wdata (q_wdata),
		.pop (q_pop),
		.rdata (q_rdata),
		.full (q_full),
		.not_empty (q_not_empty)
	);

	// classification and output
	pdbc_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk (clk),
		.arst_n (arst_n),
		.q_not_empty (q_not_empty),
		.q_rdata (q_rdata),
		.q_pop (q_pop),
		.cfg (cfg),
		.results (results)
	);

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// self-checking testbench for the pwm duty band classifier core
`timescale 1ns / 1ps
module testbench import pdbc_pkg::*;;

	// narrow counters so that saturation is reachable in a few hundred ticks
	localparam int TB_CNT_W = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;

	// spare register indexes, writes there must change nothing
	localparam logic [2:0] REG_SPARE_A = 3'd5;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic [CHAN_W-1:0] chan;
		band_t band;
	} band_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	pdbc_sample_if smp();
	pdbc_result_if res();

	pwm_duty_band_classifier_core #(.COUNT_WIDTH(TB_CNT_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(smp),
		.results(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// duty tracker state and register shadow
	phase_t tick_phase = PH_WAIT;
	logic [TB_CNT_W-1:0] period_cnt = '0;
	logic [TB_CNT_W-1:0] high_cnt = '0;
	cfg_t shadow_cfg = '{RST_CHANNEL_ID, RST_HIGH_LOWER, RST_MID_LOWER, RST_LOW_LOWER,
		RST_LOW_UPPER};
	band_word_t pending_bands[$];

	int mismatches = 0;
	int samples_sent = 0;
	int bands_checked = 0;
	int settings_applied = 0;
	int input_stalls = 0;
	int send_idle_pct = 9;
	int recv_idle_pct = 52;
	int hold_left = 0;
	int quiet_cycles = 0;

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// strict window test, lo < 1000*h/p < hi done by cross-multiplication
	function automatic bit in_window(input longint unsigned scaled, input longint unsigned per,
			input logic [BOUND_W-1:0] lo, input logic [BOUND_W-1:0] hi);
		return scaled > lo * per && scaled < hi * per;
	endfunction

	function automatic band_t band_of(input logic [TB_CNT_W-1:0] high_n,
			input logic [TB_CNT_W-1:0] period_n);
		longint unsigned scaled;
		longint unsigned per;
		scaled = high_n;
		scaled = scaled * DUTY_SCALE;
		per = period_n;
		if (in_window(scaled, per, shadow_cfg.high_lower, shadow_cfg.mid_lower))
			return BAND_HIGH;
		if (in_window(scaled, per, shadow_cfg.mid_lower, shadow_cfg.low_lower))
			return BAND_MID;
		if (in_window(scaled, per, shadow_cfg.low_lower, shadow_cfg.low_upper))
			return BAND_LOW;
		return BAND_ERROR;
	endfunction

	// advance the duty tracker by one pin sample, queue a band on a closing edge
	function automatic void predict_tick(input logic lvl);
		band_word_t w;
		case (tick_phase)
			PH_HIGH: begin
				if (period_cnt != '1) period_cnt++;
				if (lvl) begin
					if (high_cnt != '1) high_cnt++;
				end else begin
					tick_phase = PH_LOW;
				end
			end
			PH_LOW: begin
				if (lvl) begin
					w.chan = shadow_cfg.channel_id;
					w.band = band_of(high_cnt, period_cnt);
					pending_bands.insert(pending_bands.size(), w);
					period_cnt = TB_CNT_W'(1);
					high_cnt = TB_CNT_W'(1);
					tick_phase = PH_HIGH;
				end else if (period_cnt != '1) begin
					period_cnt++;
				end
			end
			default: begin
				if (lvl) begin
					period_cnt = TB_CNT_W'(1);
					high_cnt = TB_CNT_W'(1);
					tick_phase = PH_HIGH;
				end
			end
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] reg_value(input logic [2:0] idx);
		case (idx)
			REG_CHANNEL_ID: return DATA_W'(shadow_cfg.channel_id);
			REG_HIGH_LOWER: return DATA_W'(shadow_cfg.high_lower);
			REG_MID_LOWER: return DATA_W'(shadow_cfg.mid_lower);
			REG_LOW_LOWER: return DATA_W'(shadow_cfg.low_lower);
			REG_LOW_UPPER: return DATA_W'(shadow_cfg.low_upper);
			default: return '0;
		endcase
	endfunction

	// one apb transfer, setup then access, entered and left at a falling edge
	task automatic apb_access(input bit wr, input logic [2:0] idx,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] ignored;
		apb_access(1'b1, idx, value, ignored);
		case (idx)
			REG_CHANNEL_ID: shadow_cfg.channel_id = value[CHAN_W-1:0];
			REG_HIGH_LOWER: shadow_cfg.high_lower = value[BOUND_W-1:0];
			REG_MID_LOWER: shadow_cfg.mid_lower = value[BOUND_W-1:0];
			REG_LOW_LOWER: shadow_cfg.low_lower = value[BOUND_W-1:0];
			REG_LOW_UPPER: shadow_cfg.low_upper = value[BOUND_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_regs();
		logic [DATA_W-1:0] rd;
		for (int i = REG_CHANNEL_ID; i <= REG_LOW_UPPER; i++) begin
			apb_access(1'b0, 3'(i), '0, rd);
			if (rd !== reg_value(3'(i)))
				flag_mismatch($sformatf("register %0d read %0h expected %0h", i, rd,
					reg_value(3'(i))));
		end
	endtask

	// stop sending, let every pending band come out and the pipeline settle
	task automatic wait_idle();
		smp.valid <= 1'b0;
		while (pending_bands.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_bands(input logic [DATA_W-1:0] chan, input logic [DATA_W-1:0] hl,
			input logic [DATA_W-1:0] ml, input logic [DATA_W-1:0] ll,
			input logic [DATA_W-1:0] lu);
		wait_idle();
		set_reg(REG_CHANNEL_ID, chan);
		set_reg(REG_HIGH_LOWER, hl);
		set_reg(REG_MID_LOWER, ml);
		set_reg(REG_LOW_LOWER, ll);
		set_reg(REG_LOW_UPPER, lu);
		check_regs();
		settings_applied++;
	endtask

	// one sample word, with random idle cycles in front of it
	task automatic send_sample(input logic lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			smp.valid <= 1'b0;
			@(negedge clk);
		end
		smp.valid <= 1'b1;
		smp.pin_level <= lvl;
		@(posedge clk);
		while (!smp.ready) begin
			input_stalls++;
			@(posedge clk);
		end
		predict_tick(lvl);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_run(input logic lvl, input int n);
		repeat (n) send_sample(lvl);
	endtask

	task automatic send_bits(input string pattern);
		for (int i = 0; i < pattern.len(); i++)
			send_sample(pattern[i] == "1");
	endtask

	// mostly clean pulses of random shape, some random noise in between
	task automatic drive_pwm(input int count);
		int sent;
		int max_len;
		int hi_len;
		int lo_len;
		int k;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 15) begin
				k = $urandom_range(1, 6);
				repeat (k) send_sample(1'($urandom_range(1)));
				sent += k;
			end else begin
				max_len = ($urandom_range(99) < 10) ? 40 : 10;
				hi_len = $urandom_range(1, max_len);
				lo_len = $urandom_range(1, max_len);
				send_run(1'b1, hi_len);
				send_run(1'b0, lo_len);
				sent += hi_len + lo_len;
			end
		end
	endtask

	// reset values read back, first rising edge opens a period
	task automatic test_reset_defaults();
		check_regs();
		send_bits("0100000001");
	endtask

	// exact boundaries give error, each band reached once
	task automatic test_directed();
		set_bands(32'd255, 32'd250, 32'd500, 32'd750, 32'd1000);
		send_bits("0001");
		send_bits("01");
		send_bits("001");
		send_bits("101");
		send_bits("11101");
	endtask

	// masked all-ones, all-zero, full range and overlapping windows
	task automatic test_band_extremes();
		set_bands('1, '1, '1, '1, '1);
		set_reg(REG_SPARE_A, '1);
		set_reg(REG_SPARE_B, '0);
		check_regs();
		drive_pwm(10);
		set_bands('0, '0, '0, '0, '0);
		drive_pwm(10);
		set_bands(32'd17, 32'd0, 32'd333, 32'd666, 32'd1000);
		drive_pwm(10);
		set_bands(32'd60, 32'd0, 32'd600, 32'd300, 32'd1000);
		drive_pwm(10);
	endtask

	// random bands under each idling mix
	task automatic test_random_traffic();
		int unsigned v[$];
		for (int mode = 0; mode < 3; mode++) begin
			v.delete();
			repeat (4) v.insert(v.size(), $urandom_range(0, DUTY_SCALE));
			if ($urandom_range(3) != 0) v.sort();
			set_bands($urandom, v[0], v[1], v[2], v[3]);
			send_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 52 : 0;
			recv_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 9 : 0;
			drive_pwm(25);
		end
	endtask

	// long result hold-off fills the queue and must stall the sample input
	task automatic test_backpressure();
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = HOLD_CYCLES;
		repeat (14) send_bits("10");
		wait_idle();
	endtask

	// both counters pinned at full scale, period held through the low part
	task automatic test_saturation();
		set_bands(32'h5A, 32'd30, 32'd100, 32'd500, 32'h0000_FFFF);
		send_run(1'b1, 260);
		send_run(1'b0, 3);
		send_run(1'b1, 1);
	endtask

	// result receiver, random ready with an optional long hold-off
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res.ready <= 1'b0;
				hold_left--;
			end else begin
				res.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// compare each band word against the oldest prediction
	always @(posedge clk) begin : check_bands
		band_word_t want;
		if (arst_n && res.valid && res.ready) begin
			if (pending_bands.size() == 0) begin
				flag_mismatch($sformatf("band word %0d/%0d with nothing pending",
					res.channel_index, res.band_code));
			end else begin
				want = pending_bands.pop_front();
				if (res.channel_index !== want.chan)
					flag_mismatch($sformatf("channel_index %0d expected %0d",
						res.channel_index, want.chan));
				if (res.band_code !== want.band)
					flag_mismatch($sformatf("band_code %0d expected %s",
						res.band_code, want.band.name()));
				bands_checked++;
			end
		end
	end

	// watchdog on cycles with no accepted word or register access
	always @(posedge clk) begin
		if (!arst_n || (smp.valid && smp.ready) || (res.valid && res.ready)
				|| (psel && penable && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		smp.valid = 1'b0;
		smp.pin_level = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_directed();
		test_band_extremes();
		test_random_traffic();
		test_backpressure();
		test_saturation();
		wait_idle();
		$display("covered %0d pin samples, %0d band words, %0d band settings",
			samples_sent, bands_checked, settings_applied);
		$display("sample input held off on %0d cycles by result back-pressure",
			input_stalls);
		if (mismatches == 0 && pending_bands.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
